FILE: rtl/assert_macros.svh
// assertion macros for the rtl of the ordered list block, included by ordered_list_insert_delete
// no dependencies; expects clk_i and rst_ni in the including scope
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked at every clock edge outside reset
`define OLID_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// implication checked at the clock after the trigger
`define OLID_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/olid_pkg.sv
// types, codes and sizes for the ordered list block
// no dependencies; used by olid_cell and ordered_list_insert_delete
package olid_pkg;

  localparam int CAPACITY = 16;
  localparam int WORD_W   = 32;
  localparam int POS_W    = 4;
  localparam int KIND_W   = 3;
  localparam int ENTRY_W  = 5;
  localparam int STAT_W   = 2;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int CMP_W    = (CNT_W > POS_W) ? CNT_W : POS_W;

  localparam logic [WORD_W-1:0] ERR_WORD = {1'b1, {(WORD_W-1){1'b0}}};

  typedef enum logic [KIND_W-1:0] {
    KIND_APPEND   = 3'd0,
    KIND_INSERT   = 3'd1,
    KIND_DEL_LAST = 3'd2,
    KIND_DEL_AT   = 3'd3,
    KIND_READ     = 3'd4
  } kind_e;

  typedef enum logic [STAT_W-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2,
    ST_RANGE = 2'd3
  } status_e;

  // per-cell update select
  typedef struct packed {
    logic load;
    logic shift_up;
    logic shift_down;
  } cell_ctl_t;

endpackage

FILE: rtl/ordered_list_insert_delete.sv
// top level of the ordered list block: request decode, row of cells, result register
// depends on olid_pkg, olid_cell and assert_macros.svh
//
//   channel | direction | handshake                | word
//   --------+-----------+--------------------------+---------------------------------
//   in      | to block  | in_valid_i / in_stall_o  | kind_i, value_i, position_i
//   out     | from block| out_valid_o / out_stall_i| read_value_o, entry_count_o, status_o
//
// one request per cycle while in_stall_o is low: the chosen cells shift or load in the same edge that accepts the word
// the result appears in the cycle after acceptance, held in the output register
// in_stall_o rises only while a finished result waits under out_stall_i
// reset clears the entry count and the output valid; the cell contents stay unknown
`include "assert_macros.svh"

module ordered_list_insert_delete (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic        [olid_pkg::KIND_W-1:0]  kind_i,
  input  logic signed [olid_pkg::WORD_W-1:0]  value_i,
  input  logic        [olid_pkg::POS_W-1:0]   position_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic signed [olid_pkg::WORD_W-1:0]  read_value_o,
  output logic        [olid_pkg::ENTRY_W-1:0] entry_count_o,
  output logic        [olid_pkg::STAT_W-1:0]  status_o
);

  localparam int Cap  = olid_pkg::CAPACITY;
  localparam int CmpW = olid_pkg::CMP_W;

  // list state
  logic [olid_pkg::CNT_W-1:0]  count_q, count_d;
  logic [olid_pkg::WORD_W-1:0] entries [Cap];
  olid_pkg::cell_ctl_t         cell_ctl [Cap];

  // result register
  logic                         out_valid_q, out_valid_d;
  logic [olid_pkg::WORD_W-1:0]  read_value_q, word_d;
  logic [olid_pkg::ENTRY_W-1:0] entry_count_q;
  olid_pkg::status_e            status_q, status_d;

  // request decode
  logic            acc;
  logic            full, empty;
  logic            do_app, do_ins, do_del;
  logic [CmpW-1:0] pos_ext, cnt_ext;
  logic [olid_pkg::WORD_W-1:0] rd_word;

  // a new word may enter whenever the result slot is free or being drained
  assign in_stall_o = out_valid_q && out_stall_i;
  assign acc        = in_valid_i && !in_stall_o;

  assign pos_ext = CmpW'(position_i);
  assign cnt_ext = CmpW'(count_q);
  assign full    = count_q >= olid_pkg::CNT_W'(Cap);
  assign empty   = count_q == '0;

  // read select: and-or over the row
  always_comb begin
    rd_word = '0;
    for (int i = 0; i < Cap; i++) begin
      if (CmpW'(i) == pos_ext) begin
        rd_word = rd_word | entries[i];
      end
    end
  end

  // status, result word and new count
  always_comb begin
    status_d = olid_pkg::ST_OK;
    word_d   = '0;
    count_d  = count_q;
    do_app   = 1'b0;
    do_ins   = 1'b0;
    do_del   = 1'b0;
    unique case (kind_i)
      olid_pkg::KIND_APPEND: begin
        if (full) begin
          status_d = olid_pkg::ST_FULL;
          word_d   = olid_pkg::ERR_WORD;
        end else begin
          do_app  = 1'b1;
          count_d = olid_pkg::CNT_W'(count_q + 1'b1);
        end
      end
      olid_pkg::KIND_INSERT: begin
        if (full) begin
          status_d = olid_pkg::ST_FULL;
          word_d   = olid_pkg::ERR_WORD;
        end else if (pos_ext > cnt_ext) begin
          status_d = olid_pkg::ST_RANGE;
          word_d   = olid_pkg::ERR_WORD;
        end else begin
          do_ins  = 1'b1;
          count_d = olid_pkg::CNT_W'(count_q + 1'b1);
        end
      end
      olid_pkg::KIND_DEL_LAST: begin
        if (empty) begin
          status_d = olid_pkg::ST_EMPTY;
          word_d   = olid_pkg::ERR_WORD;
        end else begin
          count_d = olid_pkg::CNT_W'(count_q - 1'b1);
        end
      end
      olid_pkg::KIND_DEL_AT: begin
        if (empty) begin
          status_d = olid_pkg::ST_EMPTY;
          word_d   = olid_pkg::ERR_WORD;
        end else if (pos_ext >= cnt_ext) begin
          status_d = olid_pkg::ST_RANGE;
          word_d   = olid_pkg::ERR_WORD;
        end else begin
          do_del  = 1'b1;
          count_d = olid_pkg::CNT_W'(count_q - 1'b1);
        end
      end
      olid_pkg::KIND_READ: begin
        if (empty) begin
          status_d = olid_pkg::ST_EMPTY;
          word_d   = olid_pkg::ERR_WORD;
        end else if (pos_ext >= cnt_ext) begin
          status_d = olid_pkg::ST_RANGE;
          word_d   = olid_pkg::ERR_WORD;
        end else begin
          word_d = rd_word;
        end
      end
      // unused kinds pass through with ok and zero
      default: begin
        status_d = olid_pkg::ST_OK;
      end
    endcase
  end

  // per-cell selects: append loads the slot at the count, insert loads the slot at
  // the position and moves everything above it up, delete-at pulls everything from the
  // position on down by one
  always_comb begin
    for (int i = 0; i < Cap; i++) begin
      cell_ctl[i].load       = acc && ((do_app && CmpW'(i) == cnt_ext) ||
                                       (do_ins && CmpW'(i) == pos_ext));
      cell_ctl[i].shift_up   = acc && do_ins && (CmpW'(i) > pos_ext);
      cell_ctl[i].shift_down = acc && do_del && (CmpW'(i) >= pos_ext);
    end
  end

  // row of cells, each wired to the neighbors it has; the ends take value_i and their own word
  for (genvar i = 0; i < Cap; i++) begin : g_cell
    logic [olid_pkg::WORD_W-1:0] left_w, right_w;

    if (i == 0) begin : g_first
      assign left_w = value_i;
    end else begin : g_left
      assign left_w = entries[i-1];
    end

    // the top slot never pulls from above; it keeps its own word
    if (i == Cap - 1) begin : g_last
      assign right_w = entries[i];
    end else begin : g_right
      assign right_w = entries[i+1];
    end

    olid_cell u_cell (
      .clk_i   (clk_i),
      .ctl_i   (cell_ctl[i]),
      .value_i (value_i),
      .left_i  (left_w),
      .right_i (right_w),
      .entry_o (entries[i])
    );
  end

  // count register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (acc) begin
      count_q <= count_d;
    end
  end

  // result valid: set on accept, cleared once taken
  always_comb begin
    priority if (acc) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  // result payload, loaded only on accept so a stalled word holds
  always_ff @(posedge clk_i) begin
    if (acc) begin
      read_value_q  <= word_d;
      entry_count_q <= olid_pkg::ENTRY_W'(count_d);
      status_q      <= status_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign read_value_o  = read_value_q;
  assign entry_count_o = entry_count_q;
  assign status_o      = status_q;

  // checks
  `OLID_ASSERT(a_count_bound, count_q <= olid_pkg::CNT_W'(Cap),
    "entry count above capacity")
  `OLID_ASSERT_NEXT(a_refused_keeps_count, acc && status_d != olid_pkg::ST_OK,
    count_q == $past(count_q), "refused request changed the entry count")
  `OLID_ASSERT_NEXT(a_append_grows, acc && do_app,
    count_q == olid_pkg::CNT_W'($past(count_q) + 1'b1), "append did not grow the list")
  `OLID_ASSERT_NEXT(a_accept_gives_result, acc,
    out_valid_q, "accepted word produced no result")

endmodule

FILE: rtl/olid_cell.sv
// one list slot: holds a word, loads the request word or a neighbor's word
// depends on olid_pkg
module olid_cell (
  input  logic                         clk_i,
  input  olid_pkg::cell_ctl_t          ctl_i,
  input  logic [olid_pkg::WORD_W-1:0]  value_i,
  input  logic [olid_pkg::WORD_W-1:0]  left_i,
  input  logic [olid_pkg::WORD_W-1:0]  right_i,
  output logic [olid_pkg::WORD_W-1:0]  entry_o
);

  logic [olid_pkg::WORD_W-1:0] entry_q, entry_d;

  always_comb begin
    priority if (ctl_i.load) begin
      entry_d = value_i;
    end else if (ctl_i.shift_up) begin
      entry_d = left_i;
    end else if (ctl_i.shift_down) begin
      entry_d = right_i;
    end else begin
      entry_d = entry_q;
    end
  end

  // payload only, no reset
  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign entry_o = entry_q;

endmodule

FILE: verif/tb_ordered_list_insert_delete.sv
// testbench for the ordered list block: table of directed words, then random phases
// depends on olid_pkg and the rtl of ordered_list_insert_delete; self-checking, no files
module tb_ordered_list_insert_delete;
  import olid_pkg::*;

  // kinds that the block ignores
  localparam logic [KIND_W-1:0] KIND_SPARE_LO = 3'd5;
  localparam logic [KIND_W-1:0] KIND_SPARE_HI = 3'd7;

  localparam int ITEMS_PER_PHASE = 670;
  localparam int HOLD_CYCLES     = 60;
  localparam int MAX_REPORTS     = 10;
  localparam int DIR_ROWS        = 25;

  // one result word as the block returns it
  typedef struct packed {
    logic signed [WORD_W-1:0]  read_value;
    logic        [ENTRY_W-1:0] entry_count;
    logic        [STAT_W-1:0]  status;
  } list_result_t;

  // one row of the directed table; typed_in marks a result written out by hand
  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [WORD_W-1:0] value;
    logic [POS_W-1:0]  pos;
    logic [4:0]        reps;
    logic              typed_in;
    list_result_t      want;
  } dir_row_t;

  localparam dir_row_t DIR_TAB [DIR_ROWS] = '{
    // empty list: every removal and read is refused
    '{KIND_READ,     32'h0,        4'd0,  5'd1,  1'b1, '{ERR_WORD, 5'd0,  ST_EMPTY}},
    '{KIND_DEL_LAST, 32'h0,        4'd0,  5'd1,  1'b1, '{ERR_WORD, 5'd0,  ST_EMPTY}},
    '{KIND_DEL_AT,   32'h0,        4'd0,  5'd1,  1'b1, '{ERR_WORD, 5'd0,  ST_EMPTY}},
    // insert past the count
    '{KIND_INSERT,   32'h12345678, 4'd1,  5'd1,  1'b1, '{ERR_WORD, 5'd0,  ST_RANGE}},
    // value extremes go in and come back
    '{KIND_INSERT,   32'h7fffffff, 4'd0,  5'd1,  1'b1, '{32'sh0,   5'd1,  ST_OK}},
    '{KIND_APPEND,   32'h80000000, 4'd9,  5'd1,  1'b1, '{32'sh0,   5'd2,  ST_OK}},
    '{KIND_READ,     32'h0,        4'd0,  5'd1,  1'b1, '{32'sh7fffffff, 5'd2, ST_OK}},
    '{KIND_READ,     32'h0,        4'd1,  5'd1,  1'b1, '{ERR_WORD, 5'd2,  ST_OK}},
    // read at a position equal to the count
    '{KIND_READ,     32'h0,        4'd2,  5'd1,  1'b1, '{ERR_WORD, 5'd2,  ST_RANGE}},
    // insert at the count acts as an append
    '{KIND_INSERT,   32'hffffffff, 4'd2,  5'd1,  1'b1, '{32'sh0,   5'd3,  ST_OK}},
    '{KIND_INSERT,   32'h0,        4'd1,  5'd1,  1'b0, '{32'sh0,   5'd0,  ST_OK}},
    '{KIND_DEL_AT,   32'h0,        4'd4,  5'd1,  1'b1, '{ERR_WORD, 5'd4,  ST_RANGE}},
    '{KIND_DEL_AT,   32'h0,        4'd0,  5'd1,  1'b0, '{32'sh0,   5'd0,  ST_OK}},
    // spare kinds change nothing
    '{KIND_SPARE_LO, 32'ha5a5a5a5, 4'd15, 5'd1,  1'b1, '{32'sh0,   5'd3,  ST_OK}},
    '{KIND_SPARE_HI, 32'hffffffff, 4'd15, 5'd1,  1'b1, '{32'sh0,   5'd3,  ST_OK}},
    '{KIND_READ,     32'h0,        4'd2,  5'd1,  1'b0, '{32'sh0,   5'd0,  ST_OK}},
    // fill up to capacity, then hit the full list
    '{KIND_APPEND,   32'h5a5a5a5a, 4'd0,  5'd13, 1'b0, '{32'sh0,   5'd0,  ST_OK}},
    '{KIND_APPEND,   32'h1,        4'd0,  5'd1,  1'b1, '{ERR_WORD, 5'd16, ST_FULL}},
    '{KIND_INSERT,   32'h1,        4'd0,  5'd1,  1'b1, '{ERR_WORD, 5'd16, ST_FULL}},
    '{KIND_READ,     32'h0,        4'd15, 5'd1,  1'b0, '{32'sh0,   5'd0,  ST_OK}},
    '{KIND_DEL_AT,   32'h0,        4'd15, 5'd1,  1'b1, '{32'sh0,   5'd15, ST_OK}},
    '{KIND_DEL_LAST, 32'h0,        4'd0,  5'd1,  1'b1, '{32'sh0,   5'd14, ST_OK}},
    '{KIND_INSERT,   32'h2,        4'd15, 5'd1,  1'b1, '{ERR_WORD, 5'd14, ST_RANGE}},
    '{KIND_INSERT,   32'h1,        4'd14, 5'd1,  1'b0, '{32'sh0,   5'd0,  ST_OK}},
    '{KIND_READ,     32'h0,        4'd15, 5'd1,  1'b1, '{ERR_WORD, 5'd15, ST_RANGE}}
  };

  logic                      clk_i       = 1'b0;
  logic                      rst_ni      = 1'b0;
  logic                      in_valid_i  = 1'b0;
  logic                      in_stall_o;
  logic        [KIND_W-1:0]  kind_i      = '0;
  logic signed [WORD_W-1:0]  value_i     = '0;
  logic        [POS_W-1:0]   position_i  = '0;
  logic                      out_valid_o;
  logic                      out_stall_i = 1'b0;
  logic signed [WORD_W-1:0]  read_value_o;
  logic        [ENTRY_W-1:0] entry_count_o;
  logic        [STAT_W-1:0]  status_o;

  // shadow of the list as the block should hold it
  logic signed [WORD_W-1:0] list_mem [CAPACITY];
  int                       list_len = 0;
  bit                       growing  = 1'b1;

  list_result_t pending_results [$];
  list_result_t head_result;
  int           bad_results = 0;

  // idle rates in percent per cycle, changed per phase
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;

  // long receiver hold-off, asked for by the stimulus and counted by the receiver
  int holds_asked = 0;
  int holds_done  = 0;
  int hold_left   = 0;

  ordered_list_insert_delete dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .kind_i        (kind_i),
    .value_i       (value_i),
    .position_i    (position_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .read_value_o  (read_value_o),
    .entry_count_o (entry_count_o),
    .status_o      (status_o)
  );

  always #6 clk_i = ~clk_i;

  // apply one request to the shadow list and return the word the block should give back
  function automatic list_result_t apply_request(input logic [KIND_W-1:0] k,
                                                 input logic signed [WORD_W-1:0] v,
                                                 input logic [POS_W-1:0] p);
    list_result_t r;
    int           slot;
    int           i;
    r.read_value = '0;
    r.status     = ST_OK;
    case (k)
      KIND_APPEND, KIND_INSERT: begin
        if (list_len >= CAPACITY) begin
          r.read_value = ERR_WORD;
          r.status     = ST_FULL;
        end else if (k == KIND_INSERT && int'(p) > list_len) begin
          r.read_value = ERR_WORD;
          r.status     = ST_RANGE;
        end else begin
          // append lands at the count, insert opens a gap at p
          slot = (k == KIND_APPEND) ? list_len : int'(p);
          for (i = list_len; i > slot; i--) list_mem[i] = list_mem[i-1];
          list_mem[slot] = v;
          list_len++;
        end
      end
      KIND_DEL_LAST: begin
        if (list_len == 0) begin
          r.read_value = ERR_WORD;
          r.status     = ST_EMPTY;
        end else begin
          list_len--;
        end
      end
      KIND_DEL_AT, KIND_READ: begin
        if (list_len == 0) begin
          r.read_value = ERR_WORD;
          r.status     = ST_EMPTY;
        end else if (int'(p) >= list_len) begin
          r.read_value = ERR_WORD;
          r.status     = ST_RANGE;
        end else if (k == KIND_READ) begin
          r.read_value = list_mem[p];
        end else begin
          for (i = int'(p); i + 1 < list_len; i++) list_mem[i] = list_mem[i+1];
          list_len--;
        end
      end
      default: ;
    endcase
    r.entry_count = ENTRY_W'(list_len);
    return r;
  endfunction

  // offer one word, hold it until accepted, log its result, then maybe idle a while
  task automatic offer_word(input logic [KIND_W-1:0] k, input logic [WORD_W-1:0] v,
                            input logic [POS_W-1:0] p, input logic typed_in,
                            input list_result_t typed_res);
    list_result_t res;
    int           gap;
    in_valid_i <= 1'b1;
    kind_i     <= k;
    value_i    <= v;
    position_i <= p;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    res = apply_request(k, v, p);
    pending_results.push_back(typed_in ? typed_res : res);
    gap = 0;
    while (gap < 8 && $urandom_range(99) < send_idle_pct) gap++;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // random request: mostly well-formed for the current fill, drifting between full and empty
  task automatic pick_request(output logic [KIND_W-1:0] k, output logic [WORD_W-1:0] v,
                              output logic [POS_W-1:0] p);
    int roll;
    int hi;
    if (list_len >= CAPACITY) growing = 1'b0;
    else if (list_len == 0) growing = 1'b1;
    else if ($urandom_range(99) < 3) growing = !growing;
    roll = $urandom_range(99);
    if ($urandom_range(99) < 6) k = KIND_W'($urandom_range(KIND_SPARE_HI, KIND_SPARE_LO));
    else if (growing) begin
      if (roll < 35) k = KIND_APPEND;
      else if (roll < 60) k = KIND_INSERT;
      else if (roll < 70) k = KIND_DEL_LAST;
      else if (roll < 80) k = KIND_DEL_AT;
      else k = KIND_READ;
    end else begin
      if (roll < 10) k = KIND_APPEND;
      else if (roll < 20) k = KIND_INSERT;
      else if (roll < 42) k = KIND_DEL_LAST;
      else if (roll < 65) k = KIND_DEL_AT;
      else k = KIND_READ;
    end
    case ($urandom_range(9))
      0:       v = ERR_WORD;
      1:       v = 32'h7fffffff;
      2:       v = '0;
      3:       v = '1;
      default: v = $urandom;
    endcase
    // positions mostly in range, the rest anywhere
    if (k == KIND_INSERT) hi = (list_len > 15) ? 15 : list_len;
    else hi = (list_len > 0) ? list_len - 1 : 15;
    if ($urandom_range(99) < 85) p = POS_W'($urandom_range(hi, 0));
    else p = POS_W'($urandom_range(15, 0));
  endtask

  // receiver: random stalls, or a long hold-off when one is asked for
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      hold_left   <= 0;
      holds_done  <= 0;
    end else if (hold_left != 0) begin
      out_stall_i <= 1'b1;
      hold_left   <= hold_left - 1;
    end else if (holds_done != holds_asked) begin
      holds_done  <= holds_asked;
      hold_left   <= HOLD_CYCLES;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // result check: every accepted word against the oldest one still owed
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_results.size() == 0) begin
        bad_results++;
        if (bad_results <= MAX_REPORTS)
          $display("unrequested result: value %h count %0d status %0d",
                   read_value_o, entry_count_o, status_o);
      end else begin
        head_result = pending_results.pop_front();
        if (read_value_o !== head_result.read_value ||
            entry_count_o !== head_result.entry_count ||
            status_o !== head_result.status) begin
          bad_results++;
          if (bad_results <= MAX_REPORTS)
            $display("result mismatch: want %h/%0d/%0d got %h/%0d/%0d",
                     head_result.read_value, head_result.entry_count, head_result.status,
                     read_value_o, entry_count_o, status_o);
        end
      end
    end
  end

  // stimulus: reset, directed table, then three random phases with changing idle rates
  initial begin
    logic [KIND_W-1:0] k;
    logic [WORD_W-1:0] v;
    logic [POS_W-1:0]  p;
    int                phase;
    int                issued;
    int                row;
    int                rep;
    repeat (3) @(posedge clk_i);
    rst_ni         <= 1'b1;
    send_idle_pct  <= 14;
    recv_stall_pct <= 74;
    @(posedge clk_i);

    for (row = 0; row < DIR_ROWS; row++) begin
      for (rep = 0; rep < int'(DIR_TAB[row].reps); rep++)
        offer_word(DIR_TAB[row].kind, DIR_TAB[row].value, DIR_TAB[row].pos,
                   DIR_TAB[row].typed_in, DIR_TAB[row].want);
    end

    for (phase = 0; phase < 3; phase++) begin
      // sender pauses until every owed result is back
      in_valid_i <= 1'b0;
      @(posedge clk_i);
      while (pending_results.size() != 0) @(posedge clk_i);
      send_idle_pct  <= (phase == 0) ? 14 : (phase == 1) ? 74 : 0;
      recv_stall_pct <= (phase == 0) ? 74 : (phase == 1) ? 14 : 0;
      issued = 0;
      while (issued < ITEMS_PER_PHASE) begin
        // long hold-off with a gapless sender: the block backs up and stalls its input
        if (phase == 2 && issued == 60) holds_asked <= holds_asked + 1;
        pick_request(k, v, p);
        offer_word(k, v, p, 1'b0, '0);
        if (k <= KIND_READ) issued++;
      end
    end

    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_results.size() != 0) @(posedge clk_i);
    // wait on to catch any stray result
    repeat (8) @(posedge clk_i);
    if (bad_results == 0 && pending_results.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // hang guard, far beyond the slowest correct run
  initial begin
    #6000000;
    $display("TEST FAILED");
    $finish;
  end

endmodule

FILE: sim.f
+incdir+rtl
rtl/olid_pkg.sv
rtl/olid_cell.sv
rtl/ordered_list_insert_delete.sv
verif/tb_ordered_list_insert_delete.sv
